[design/rrss_pkg.sv]
// ----------------------------------------------------------------------------
// rrss_pkg: shared types and constants of the round-robin sleep scheduler
// Field widths, event kinds, status codes, slot states and the result
// bundle handed from the sequencer to the output stage.
// ----------------------------------------------------------------------------
package rrss_pkg;

  localparam int KIND_W   = 3;
  localparam int MS_W     = 16;
  localparam int SP_W     = 32;
  localparam int STATUS_W = 2;
  localparam int PID_W    = 16;
  localparam int TPM_W    = 10;
  localparam int WAIT_W   = 27;
  localparam int GEN_W    = 10;
  localparam int PROD_W   = MS_W + TPM_W;

  localparam logic [TPM_W-1:0] TPM_RESET = TPM_W'(55);

  localparam logic [KIND_W-1:0] KIND_TICK   = KIND_W'(0);
  localparam logic [KIND_W-1:0] KIND_SCHED  = KIND_W'(1);
  localparam logic [KIND_W-1:0] KIND_SLEEP  = KIND_W'(2);
  localparam logic [KIND_W-1:0] KIND_CREATE = KIND_W'(3);
  localparam logic [KIND_W-1:0] KIND_SAVE   = KIND_W'(4);

  localparam logic [STATUS_W-1:0] STATUS_OK      = STATUS_W'(0);
  localparam logic [STATUS_W-1:0] STATUS_NO_FREE = STATUS_W'(1);
  localparam logic [STATUS_W-1:0] STATUS_IDLE    = STATUS_W'(2);

  typedef enum logic [1:0] {
    ST_FREE    = 2'd0,
    ST_READY   = 2'd1,
    ST_RUNNING = 2'd2,
    ST_WAITING = 2'd3
  } slot_state_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PID_W-1:0]    pid;
    logic [SP_W-1:0]     saved_stack;
    logic [PID_W-1:0]    current_pid;
  } result_t;

endpackage

[design/rrss_ram.sv]
// ----------------------------------------------------------------------------
// rrss_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module rrss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/rrss_ctrl.sv]
// ----------------------------------------------------------------------------
// rrss_ctrl: slot table and event sequencer
// Walks the slot ring through one row RAM, one slot per cycle, and applies
// tick, schedule, sleep, create and save events.
// ----------------------------------------------------------------------------
module rrss_ctrl #(
  parameter int NUM_SLOTS = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [rrss_pkg::KIND_W-1:0]     kind,
  input  logic [rrss_pkg::MS_W-1:0]       sleep_ms,
  input  logic [rrss_pkg::SP_W-1:0]       stack_pointer,
  input  logic [rrss_pkg::TPM_W-1:0]      ticks_per_ms,
  output logic                            idle,
  output logic                            res_valid,
  input  logic                            res_ready,
  output rrss_pkg::result_t               res
);

  import rrss_pkg::*;

  localparam int AW = $clog2(NUM_SLOTS);
  localparam logic [AW-1:0] LAST = AW'(NUM_SLOTS - 1);

  typedef struct packed {
    slot_state_t       st;
    logic [WAIT_W-1:0] wait_cnt;
    logic [AW-1:0]     nxt;
    logic [GEN_W-1:0]  gen;
  } row_t;

  localparam int RW = $bits(row_t);

  typedef enum logic [3:0] {
    S_IDLE,
    S_TICK,
    S_SCH_CUR,
    S_SCH_WALK,
    S_SLEEP,
    S_CR_CUR,
    S_CR_SCAN,
    S_CR_LINK,
    S_FINISH
  } fsm_t;

  function automatic logic [PID_W-1:0] slot_pid(logic [GEN_W-1:0] g, logic [AW-1:0] s);
    logic [31:0] p;
    p = 32'(g) * 32'(NUM_SLOTS) + 32'(s);
    return p[PID_W-1:0];
  endfunction

  fsm_t                state;
  logic [AW-1:0]       cur_slot;
  logic [GEN_W-1:0]    cur_gen;
  logic [AW-1:0]       rd_addr;
  logic [AW-1:0]       cnt;
  logic [AW-1:0]       free_slot;
  logic [NUM_SLOTS-1:0] valid;
  logic                fwd_hit;
  row_t                fwd_row;
  row_t                cur_row;
  logic [MS_W-1:0]     ms_q;
  logic [SP_W-1:0]     sp_q;
  logic [STATUS_W-1:0] res_status;
  logic [PID_W-1:0]    res_pid;
  logic [SP_W-1:0]     res_sso;

  logic                row_we;
  logic [AW-1:0]       row_waddr;
  row_t                row_wdata;
  logic [AW-1:0]       row_raddr;
  logic [RW-1:0]       row_rdata;
  logic                stk_we;
  logic [AW-1:0]       stk_waddr;
  logic [SP_W-1:0]     stk_wdata;
  logic [SP_W-1:0]     stk_rdata;

  row_t                row_rd;
  row_t                tick_row;
  logic                tick_wr;
  logic                tick_end;
  logic [PROD_W-1:0]   sleep_prod;

  rrss_ram #(.WIDTH(RW), .DEPTH(NUM_SLOTS)) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (row_wdata),
    .raddr (row_raddr),
    .rdata (row_rdata)
  );

  rrss_ram #(.WIDTH(SP_W), .DEPTH(NUM_SLOTS)) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (row_raddr),
    .rdata (stk_rdata)
  );

  // row as seen this cycle: bypass a same-edge write, rows never written read as reset
  always_comb begin
    if (fwd_hit) begin
      row_rd = fwd_row;
    end else if (valid[rd_addr]) begin
      row_rd = row_t'(row_rdata);
    end else begin
      row_rd    = '0;
      row_rd.st = (rd_addr == '0) ? ST_RUNNING : ST_FREE;
    end
  end

  always_comb begin
    tick_row = row_rd;
    tick_wr  = (row_rd.st == ST_WAITING);
    if (tick_wr) begin
      if (row_rd.wait_cnt == '0) begin
        tick_row.st = ST_READY;
      end else begin
        tick_row.wait_cnt = row_rd.wait_cnt - 1'b1;
        if (row_rd.wait_cnt == WAIT_W'(1)) begin
          tick_row.st = ST_READY;
        end
      end
    end
  end

  assign tick_end   = (row_rd.nxt == cur_slot) || (cnt == LAST);
  assign sleep_prod = ms_q * ticks_per_ms;

  always_comb begin
    row_raddr = rd_addr;
    row_we    = 1'b0;
    row_waddr = rd_addr;
    row_wdata = row_rd;
    stk_we    = 1'b0;
    stk_waddr = cur_slot;
    stk_wdata = sp_q;
    case (state)
      S_IDLE: begin
        row_raddr = cur_slot;
        if (start && kind == KIND_SAVE) begin
          stk_we    = 1'b1;
          stk_wdata = stack_pointer;
        end
      end
      S_TICK: begin
        row_we    = tick_wr;
        row_wdata = tick_row;
        if (!tick_end) begin
          row_raddr = row_rd.nxt;
        end
      end
      S_SCH_CUR: begin
        if (row_rd.st == ST_RUNNING) begin
          row_we       = 1'b1;
          row_wdata.st = ST_READY;
        end
        row_raddr = row_rd.nxt;
      end
      S_SCH_WALK: begin
        if (row_rd.st == ST_READY) begin
          row_we       = 1'b1;
          row_wdata.st = ST_RUNNING;
        end else if (cnt != LAST) begin
          row_raddr = row_rd.nxt;
        end
      end
      S_SLEEP: begin
        row_we             = 1'b1;
        row_wdata.st       = ST_WAITING;
        row_wdata.wait_cnt = WAIT_W'(sleep_prod);
      end
      S_CR_CUR: begin
        row_raddr = '0;
      end
      S_CR_SCAN: begin
        if (row_rd.st == ST_FREE) begin
          row_we             = 1'b1;
          row_wdata.st       = ST_READY;
          row_wdata.wait_cnt = '0;
          row_wdata.nxt      = cur_row.nxt;
          row_wdata.gen      = GEN_W'(row_rd.gen + 1'b1);
          stk_we             = 1'b1;
          stk_waddr          = rd_addr;
        end else if (rd_addr != LAST) begin
          row_raddr = rd_addr + 1'b1;
        end
      end
      S_CR_LINK: begin
        row_we        = 1'b1;
        row_waddr     = cur_slot;
        row_wdata     = cur_row;
        row_wdata.nxt = free_slot;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rd_addr <= row_raddr;
    fwd_row <= row_wdata;
    if (rst) begin
      state    <= S_IDLE;
      cur_slot <= '0;
      cur_gen  <= '0;
      cnt      <= '0;
      valid    <= '0;
      fwd_hit  <= 1'b0;
    end else begin
      fwd_hit <= row_we && (row_waddr == row_raddr);
      if (row_we) begin
        valid[row_waddr] <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            ms_q       <= sleep_ms;
            sp_q       <= stack_pointer;
            res_status <= STATUS_OK;
            res_pid    <= '0;
            res_sso    <= '0;
            cnt        <= '0;
            case (kind)
              KIND_TICK:   state <= S_TICK;
              KIND_SCHED:  state <= S_SCH_CUR;
              KIND_SLEEP:  state <= S_SLEEP;
              KIND_CREATE: state <= S_CR_CUR;
              default:     state <= S_FINISH;
            endcase
          end
        end
        S_TICK: begin
          if (tick_end) begin
            state <= S_FINISH;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_SCH_CUR: begin
          state <= S_SCH_WALK;
        end
        S_SCH_WALK: begin
          if (row_rd.st == ST_READY) begin
            cur_slot <= rd_addr;
            cur_gen  <= row_rd.gen;
            res_pid  <= slot_pid(row_rd.gen, rd_addr);
            res_sso  <= stk_rdata;
            state    <= S_FINISH;
          end else if (cnt == LAST) begin
            res_status <= STATUS_IDLE;
            state      <= S_FINISH;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_SLEEP: begin
          state <= S_FINISH;
        end
        S_CR_CUR: begin
          cur_row <= row_rd;
          state   <= S_CR_SCAN;
        end
        S_CR_SCAN: begin
          if (row_rd.st == ST_FREE) begin
            free_slot <= rd_addr;
            res_pid   <= slot_pid(GEN_W'(row_rd.gen + 1'b1), rd_addr);
            state     <= S_CR_LINK;
          end else if (rd_addr == LAST) begin
            res_status <= STATUS_NO_FREE;
            state      <= S_FINISH;
          end
        end
        S_CR_LINK: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign idle            = (state == S_IDLE);
  assign res_valid       = (state == S_FINISH);
  assign res.status      = res_status;
  assign res.pid         = res_pid;
  assign res.saved_stack = res_sso;
  assign res.current_pid = slot_pid(cur_gen, cur_slot);

endmodule

[design/round_robin_sleep_scheduler.sv]
// ----------------------------------------------------------------------------
// round_robin_sleep_scheduler: ring of process slots with timed sleep
// Takes tick, schedule, sleep, create and save events and answers each with
// one result beat.
//
//   channel | handshake                  | payload
//   --------+----------------------------+------------------------------------
//   in      | in_valid / in_stall        | kind, sleep_ms, stack_pointer
//   out     | out_valid / out_stall      | status, pid, saved_stack_out,
//           |                            | current_pid
//   cfg     | cfg_valid / cfg_ready      | cfg_data (ticks_per_ms)
//
// one event at a time; the slot ring lives in a single-port-read RAM, so
// walks advance one slot per cycle: tick and schedule follow the ring,
// create scans upward from slot 0 for the lowest free slot, and sleep,
// save and unused kinds walk no slots.
// reset is synchronous; the table needs no clearing pass after reset.
// a finished result waits in the sequencer while out_stall holds the
// output register; no new beat is taken until it moves on.
// ----------------------------------------------------------------------------
module round_robin_sleep_scheduler #(
  parameter int NUM_SLOTS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [rrss_pkg::KIND_W-1:0]   kind,
  input  logic [rrss_pkg::MS_W-1:0]     sleep_ms,
  input  logic [rrss_pkg::SP_W-1:0]     stack_pointer,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rrss_pkg::STATUS_W-1:0] status,
  output logic [rrss_pkg::PID_W-1:0]    pid,
  output logic [rrss_pkg::SP_W-1:0]     saved_stack_out,
  output logic [rrss_pkg::PID_W-1:0]    current_pid,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rrss_pkg::TPM_W-1:0]    cfg_data
);

  import rrss_pkg::*;

  logic [TPM_W-1:0] ticks_per_ms;
  logic             idle;
  logic             res_valid;
  logic             res_ready;
  result_t          res;

  assign cfg_ready = 1'b1;
  assign in_stall  = !idle;
  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_ms <= TPM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      ticks_per_ms <= cfg_data;
    end
  end

  rrss_ctrl #(.NUM_SLOTS(NUM_SLOTS)) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .start         (in_valid && !in_stall),
    .kind          (kind),
    .sleep_ms      (sleep_ms),
    .stack_pointer (stack_pointer),
    .ticks_per_ms  (ticks_per_ms),
    .idle          (idle),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
    if (res_valid && res_ready) begin
      status          <= res.status;
      pid             <= res.pid;
      saved_stack_out <= res.saved_stack;
      current_pid     <= res.current_pid;
    end
  end

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input beat accepted while sequencer stays idle");

  a_result_loads: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_ready) |=> out_valid)
    else $error("finished result not moved to output register");

  a_fail_no_pid: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != STATUS_OK) |-> (pid == '0 && saved_stack_out == '0))
    else $error("failed event carries a pid or stack value");

  a_finish_blocks: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> in_stall)
    else $error("input open while a result is pending");
`endif

endmodule
